/* design/mir_pkg.sv */
// ----------------------------------------------------------------------------
// Metapopulation infection rates: shared package
// Sizes, item and register codes, and the command and status words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package mir_pkg;

  localparam int unsigned PATCHES = 64;
  localparam int unsigned TYPES   = 16;
  localparam int unsigned PatchW  = $clog2(PATCHES);
  localparam int unsigned TypeW   = $clog2(TYPES);
  localparam int unsigned CELLS   = PATCHES * TYPES;
  localparam int unsigned CellW   = PatchW + TypeW;

  typedef enum logic [2:0] {
    KIND_LOAD_SUS   = 3'd0,
    KIND_LOAD_INF   = 3'd1,
    KIND_LOAD_TRN   = 3'd2,
    KIND_MUT_BIT    = 3'd3,
    KIND_PATCH_LINK = 3'd4,
    KIND_DEGREE     = 3'd5,
    KIND_COMPUTE    = 3'd6,
    KIND_READ       = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    CFG_MUTATION_RATE  = 3'd0,
    CFG_DISPERSAL_RATE = 3'd1,
    CFG_LOCUS_COUNT    = 3'd2,
    CFG_TYPES_IN_USE   = 3'd3,
    CFG_PATCHES_IN_USE = 3'd4
  } cfg_index_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_AB,
    MUL_HI,
    MUL_LO
  } mul_sel_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_COMPUTE,
    EMIT_READ
  } emit_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MPREP,
    ST_MRUN,
    ST_DRAIN,
    ST_DPREP0,
    ST_DPREP1,
    ST_DRUN,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_RD4
  } ctl_state_e;

  // One accumulation step of the mixing or dispersal pass.
  typedef struct packed {
    logic              valid;
    logic              pass;    // 0 mutation, 1 dispersal
    logic              self;
    logic              first;
    logic              last;
    logic [TypeW-1:0]  j;
    logic [PatchW-1:0] k;
    logic [PatchW-1:0] i;
  } step_t;

  typedef struct packed {
    logic     load;
    logic     read_capture;
    logic     compute_start;
    logic     fm_load;
    logic     fd_load;
    step_t    step;
    mul_sel_e mul_sel;
    emit_e    emit;
  } cmd_t;

  typedef struct packed {
    logic [TypeW:0]  nt;
    logic [PatchW:0] np;
  } stat_t;

endpackage

/* design/mir_ctrl.sv */
// ----------------------------------------------------------------------------
// Metapopulation infection rates: controller
// Accepts words, walks the type and patch loops of a compute and steps the
// read product sequence.
// ----------------------------------------------------------------------------
module mir_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [2:0]    kind_i,
  input  mir_pkg::stat_t stat_i,
  output logic          busy_o,
  output mir_pkg::cmd_t cmd_o
);
  import mir_pkg::*;

  ctl_state_e        state_q, state_d;
  logic [TypeW-1:0]  j_q, j_d;
  logic [PatchW-1:0] k_q, k_d, i_q, i_d;
  logic              self_q, self_d;
  logic              after_mut_q, after_mut_d;
  logic [1:0]        dc_q, dc_d;

  logic [PatchW:0]   lim;
  logic              src_last, k_last, j_last, in_run, pass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= '0;
      k_q         <= '0;
      i_q         <= '0;
      self_q      <= 1'b1;
      after_mut_q <= 1'b0;
      dc_q        <= '0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      k_q         <= k_d;
      i_q         <= i_d;
      self_q      <= self_d;
      after_mut_q <= after_mut_d;
      dc_q        <= dc_d;
    end
  end

  assign pass     = (state_q == ST_DRUN);
  assign in_run   = (state_q == ST_MRUN) || (state_q == ST_DRUN);
  assign lim      = pass ? stat_i.np : {{(PatchW-TypeW){1'b0}}, stat_i.nt};
  assign src_last = ({1'b0, i_q} == lim - 1'b1);
  assign k_last   = ({1'b0, k_q} == stat_i.np - 1'b1);
  assign j_last   = ({1'b0, j_q} == stat_i.nt - 1'b1);
  assign busy_o   = (state_q != ST_IDLE);

  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    k_d         = k_q;
    i_d         = i_q;
    self_d      = self_q;
    after_mut_d = after_mut_q;
    dc_d        = dc_q;

    cmd_o               = '0;
    cmd_o.mul_sel       = MUL_NONE;
    cmd_o.emit          = EMIT_NONE;
    cmd_o.step.pass     = pass;
    cmd_o.step.self     = self_q;
    cmd_o.step.first    = self_q;
    cmd_o.step.last     = !self_q && src_last;
    cmd_o.step.j        = j_q;
    cmd_o.step.k        = k_q;
    cmd_o.step.i        = i_q;
    cmd_o.step.valid    = in_run;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (kind_i == KIND_COMPUTE) begin
            cmd_o.compute_start = 1'b1;
            state_d             = ST_MPREP;
          end else if (kind_i == KIND_READ) begin
            cmd_o.read_capture = 1'b1;
            state_d            = ST_RD1;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      ST_MPREP: begin
        cmd_o.fm_load = 1'b1;
        j_d    = '0;
        k_d    = '0;
        i_d    = '0;
        self_d = 1'b1;
        dc_d   = '0;
        if ((stat_i.nt == '0) || (stat_i.np == '0)) begin
          after_mut_d = 1'b0;
          state_d     = ST_DRAIN;
        end else begin
          state_d = ST_MRUN;
        end
      end
      ST_MRUN, ST_DRUN: begin
        if (self_q) begin
          self_d = 1'b0;
          i_d    = '0;
        end else if (!src_last) begin
          i_d = i_q + 1'b1;
        end else begin
          // End of one cell: move on to the next patch, then the next type.
          self_d = 1'b1;
          i_d    = '0;
          if (k_last) begin
            k_d = '0;
            if (j_last) begin
              j_d         = '0;
              dc_d        = '0;
              after_mut_d = !pass;
              state_d     = ST_DRAIN;
            end else begin
              j_d     = j_q + 1'b1;
              state_d = pass ? ST_DPREP0 : ST_MRUN;
            end
          end else begin
            k_d     = k_q + 1'b1;
            state_d = pass ? ST_DPREP0 : ST_MRUN;
          end
        end
      end
      ST_DRAIN: begin
        dc_d = dc_q + 1'b1;
        if (dc_q == 2'd2) begin
          if (after_mut_q) begin
            after_mut_d = 1'b0;
            state_d     = ST_DPREP0;
          end else begin
            cmd_o.emit = EMIT_COMPUTE;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_DPREP0: begin
        state_d = ST_DPREP1;
      end
      ST_DPREP1: begin
        cmd_o.fd_load = 1'b1;
        self_d        = 1'b1;
        state_d       = ST_DRUN;
      end
      ST_RD1: begin
        cmd_o.mul_sel = MUL_AB;
        state_d       = ST_RD2;
      end
      ST_RD2: begin
        cmd_o.mul_sel = MUL_HI;
        state_d       = ST_RD3;
      end
      ST_RD3: begin
        cmd_o.mul_sel = MUL_LO;
        state_d       = ST_RD4;
      end
      ST_RD4: begin
        cmd_o.emit = EMIT_READ;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* design/mir_datapath.sv */
// ----------------------------------------------------------------------------
// Metapopulation infection rates: datapath
// Register file, stores, the multiply-accumulate pipe of a compute and the
// shared 32x32 multiplier of a read.
// ----------------------------------------------------------------------------
module mir_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mir_pkg::cmd_t       cmd_i,
  output mir_pkg::stat_t      stat_o,
  input  logic [2:0]          kind_i,
  input  logic [5:0]          patch_i,
  input  logic [5:0]          source_patch_i,
  input  logic [3:0]          host_type_i,
  input  logic [3:0]          parasite_type_i,
  input  logic [3:0]          source_type_i,
  input  logic [31:0]         value_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output logic                done_o,
  output logic [31:0]         result_value_o,
  output logic                status_o,
  output logic                saturated_o
);
  import mir_pkg::*;

  localparam logic [23:0] OneQ16 = 24'd65536;

  // Configuration.
  logic [15:0] mu_q, dr_q;
  logic [7:0]  lc_q;
  logic [4:0]  types_q;
  logic [6:0]  patches_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q      <= '0;
      dr_q      <= '0;
      lc_q      <= 8'd1;
      types_q   <= 5'd16;
      patches_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MUTATION_RATE:  mu_q      <= cfg_data_i;
        CFG_DISPERSAL_RATE: dr_q      <= cfg_data_i;
        CFG_LOCUS_COUNT:    lc_q      <= cfg_data_i[7:0];
        CFG_TYPES_IN_USE:   types_q   <= cfg_data_i[4:0];
        CFG_PATCHES_IN_USE: patches_q <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // Limits and validity kept from the last compute.
  logic [TypeW:0]  nt_q;
  logic [PatchW:0] np_q;
  logic            valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      nt_q    <= '0;
      np_q    <= '0;
    end else if (cmd_i.compute_start) begin
      valid_q <= 1'b1;
      nt_q    <= (types_q > 5'(TYPES)) ? 5'(TYPES) : types_q;
      np_q    <= (patches_q > 7'(PATCHES)) ? 7'(PATCHES) : patches_q;
    end
  end

  assign stat_o.nt = nt_q;
  assign stat_o.np = np_q;

  // Step addresses.
  step_t           st;
  logic [CellW-1:0] self_addr, inf_addr, mix_addr;

  assign st        = cmd_i.step;
  assign self_addr = {st.k, st.j};
  assign inf_addr  = st.self ? self_addr : {st.k, st.i[TypeW-1:0]};
  assign mix_addr  = st.self ? self_addr : {st.i, st.j};

  // Write-back of a finished cell.
  logic              last3_q, pass3_q;
  logic [CellW-1:0]  waddr3_q;
  logic [55:0]       acc_q;
  logic [39:0]       acc_shr;
  logic              acc_over;
  logic [31:0]       wval;

  assign acc_shr  = acc_q[55:16];
  assign acc_over = |acc_shr[39:32];
  assign wval     = acc_over ? '1 : acc_shr[31:0];

  // Stores.
  logic [31:0] sus_mem [CELLS];
  logic [31:0] inf_mem [CELLS];
  logic [31:0] mix_mem [CELLS];
  logic [31:0] dis_mem [CELLS];
  logic [31:0] trn_mem [TYPES*TYPES];
  logic        mut_mem [TYPES*TYPES];
  logic        lnk_mem [PATCHES*PATCHES];
  logic [6:0]  deg_mem [PATCHES];

  logic [31:0] sa_q, ta_q, da_q, inf_rd_q, mix_rd_q;
  logic        mut_rd_q, lnk_rd_q;
  logic [6:0]  deg_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (kind_i == KIND_LOAD_SUS)) begin
      sus_mem[{patch_i, host_type_i}] <= value_i;
    end
    if (cmd_i.read_capture) begin
      sa_q <= sus_mem[{patch_i, host_type_i}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (kind_i == KIND_LOAD_TRN)) begin
      trn_mem[{parasite_type_i, host_type_i}] <= value_i;
    end
    if (cmd_i.read_capture) begin
      ta_q <= trn_mem[{parasite_type_i, host_type_i}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (last3_q && pass3_q) begin
      dis_mem[waddr3_q] <= wval;
    end
    if (cmd_i.read_capture) begin
      da_q <= dis_mem[{patch_i, parasite_type_i}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (kind_i == KIND_LOAD_INF)) begin
      inf_mem[{patch_i, parasite_type_i}] <= value_i;
    end
    inf_rd_q <= inf_mem[inf_addr];
  end

  always_ff @(posedge clk_i) begin
    if (last3_q && !pass3_q) begin
      mix_mem[waddr3_q] <= wval;
    end
    mix_rd_q <= mix_mem[mix_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (kind_i == KIND_MUT_BIT)) begin
      mut_mem[{parasite_type_i, source_type_i}] <= (value_i != '0);
    end
    mut_rd_q <= mut_mem[{st.j, st.i[TypeW-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (kind_i == KIND_PATCH_LINK)) begin
      lnk_mem[{patch_i, source_patch_i}] <= (value_i != '0);
    end
    lnk_rd_q <= lnk_mem[{st.k, st.i}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (kind_i == KIND_DEGREE)) begin
      deg_mem[patch_i] <= value_i[6:0];
    end
    deg_q <= deg_mem[st.k];
  end

  // Loss factors, one minus rate times count, clamped at zero.
  logic [23:0] fm_t, fd_t;
  logic        fm_over, fd_over;
  logic [16:0] factor_q;

  assign fm_t    = {8'd0, mu_q} * {16'd0, lc_q};
  assign fd_t    = {8'd0, dr_q} * {17'd0, deg_q};
  assign fm_over = (fm_t > OneQ16);
  assign fd_over = (fd_t > OneQ16);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fm_load) begin
      factor_q <= fm_over ? '0 : 17'(OneQ16 - fm_t);
    end else if (cmd_i.fd_load) begin
      factor_q <= fd_over ? '0 : 17'(OneQ16 - fd_t);
    end
  end

  // Multiply-accumulate pipe: read, multiply, accumulate, write back.
  logic             v1_q, self1_q, first1_q, last1_q, pass1_q;
  logic [CellW-1:0] waddr1_q;
  logic             v2_q, first2_q, last2_q, pass2_q;
  logic [CellW-1:0] waddr2_q;
  logic [48:0]      prod_q;
  logic [31:0]      data1;
  logic [16:0]      coef1;
  logic             use1;

  assign data1 = pass1_q ? mix_rd_q : inf_rd_q;
  assign coef1 = self1_q ? factor_q : {1'b0, (pass1_q ? dr_q : mu_q)};
  assign use1  = self1_q || (pass1_q ? lnk_rd_q : mut_rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      last3_q <= 1'b0;
    end else begin
      v1_q    <= st.valid;
      v2_q    <= v1_q;
      last3_q <= v2_q && last2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    self1_q  <= st.self;
    first1_q <= st.first;
    last1_q  <= st.last;
    pass1_q  <= st.pass;
    waddr1_q <= self_addr;
    first2_q <= first1_q;
    last2_q  <= last1_q;
    pass2_q  <= pass1_q;
    waddr2_q <= waddr1_q;
    prod_q   <= use1 ? ({17'd0, data1} * {32'd0, coef1}) : '0;
    pass3_q  <= pass2_q;
    waddr3_q <= waddr2_q;
    if (v2_q) begin
      acc_q <= first2_q ? {7'd0, prod_q} : (acc_q + {7'd0, prod_q});
    end
  end

  // Read product: (T * S) * D over three passes through one multiplier.
  logic [63:0] mult_q, hi_q;
  logic [31:0] lo_q, mul_a, mul_b;
  logic [64:0] rd_sum;
  logic        rd_over, inrange_q;

  always_comb begin
    mul_a = ta_q;
    mul_b = sa_q;
    unique case (cmd_i.mul_sel)
      MUL_HI:  begin mul_a = mult_q[63:32]; mul_b = da_q; end
      MUL_LO:  begin mul_a = lo_q;          mul_b = da_q; end
      default: begin mul_a = ta_q;          mul_b = sa_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_sel != MUL_NONE) begin
      mult_q <= {32'd0, mul_a} * {32'd0, mul_b};
    end
    if (cmd_i.mul_sel == MUL_HI) begin
      lo_q <= mult_q[31:0];
    end
    if (cmd_i.mul_sel == MUL_LO) begin
      hi_q <= mult_q;
    end
    if (cmd_i.read_capture) begin
      inrange_q <= ({1'b0, patch_i} < np_q) && ({1'b0, parasite_type_i} < nt_q);
    end
  end

  assign rd_sum  = {1'b0, hi_q} + {33'd0, mult_q[63:32]};
  assign rd_over = |rd_sum[64:32];

  // Sticky saturation flag.
  logic sat_q, sat_d, rd_live;

  assign rd_live = valid_q && inrange_q;

  always_comb begin
    sat_d = sat_q
          | (cmd_i.fm_load && fm_over)
          | (cmd_i.fd_load && fd_over)
          | (last3_q && acc_over)
          | ((cmd_i.emit == EMIT_READ) && rd_live && rd_over);
    if (cmd_i.compute_start) begin
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      sat_q  <= sat_d;
      done_o <= (cmd_i.emit != EMIT_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != EMIT_NONE) begin
      saturated_o <= sat_d;
      if (cmd_i.emit == EMIT_READ) begin
        status_o       <= !valid_q;
        result_value_o <= !rd_live ? '0 : (rd_over ? '1 : rd_sum[31:0]);
      end else begin
        status_o       <= 1'b0;
        result_value_o <= '0;
      end
    end
  end

endmodule

/* design/metapopulation_infection_rates.sv */
// ----------------------------------------------------------------------------
// Metapopulation infection rates: top level
// Stores host and parasite densities, mixes parasites by mutation, spreads
// them over patches by dispersal and returns infection rates on request.
// ----------------------------------------------------------------------------
// A word is taken when start_i is high and busy_o is low. Load words give no
// result. A read word makes three passes through one 32x32 multiplier and then
// gives its result word on done_o. A compute word walks every cell in use once
// per pass through a one-step-per-cycle multiply-accumulate pipe and then
// strobes done_o. The done_o strobe is high for a single cycle and result
// words hold until the next one; the receiver cannot hold them off.
module metapopulation_infection_rates (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [5:0]  patch_i,
  input  logic [5:0]  source_patch_i,
  input  logic [3:0]  host_type_i,
  input  logic [3:0]  parasite_type_i,
  input  logic [3:0]  source_type_i,
  input  logic [31:0] value_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        done_o,
  output logic [31:0] result_value_o,
  output logic        status_o,
  output logic        saturated_o
);
  import mir_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mir_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .stat_i  (stat),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  mir_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .kind_i          (kind_i),
    .patch_i         (patch_i),
    .source_patch_i  (source_patch_i),
    .host_type_i     (host_type_i),
    .parasite_type_i (parasite_type_i),
    .source_type_i   (source_type_i),
    .value_i         (value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .result_value_o  (result_value_o),
    .status_o        (status_o),
    .saturated_o     (saturated_o)
  );

endmodule

/* design/mir_checker.sv */
// ----------------------------------------------------------------------------
// Metapopulation infection rates: port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module mir_port_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [2:0]  kind_i,
  input logic        done_o,
  input logic [31:0] result_value_o,
  input logic        status_o
);
  import mir_pkg::*;

  // A load word never makes the block busy.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i != KIND_COMPUTE && kind_i != KIND_READ) |=> !busy_o)
    else $error("load word left the block busy");

  // A read word always occupies the block for its product sequence.
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && kind_i == KIND_READ) |=> busy_o)
    else $error("read word did not start a sequence");

  // A result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // A result word shows up only once the block is free again.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result word while busy");

  // A read before any compute carries a zero rate.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (result_value_o == '0))
    else $error("nonzero rate with error status");

endmodule

bind metapopulation_infection_rates mir_port_props u_mir_port_props (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .kind_i         (kind_i),
  .done_o         (done_o),
  .result_value_o (result_value_o),
  .status_o       (status_o)
);
